@@ rtl/opp_pkg.sv @@
// Shared types and constants for the operator precedence parser.
package opp_pkg;

  localparam int FUNC_W  = 2;
  localparam int SYM_W   = 8;
  localparam int IDX_W   = 4;
  localparam int REL_W   = 2;
  localparam int STAT_W  = 2;
  localparam int RED_W   = 6;
  localparam int DEPTH_W = 7;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic [SYM_W-1:0] SYM_END  = 8'h24;
  localparam logic [SYM_W-1:0] SYM_MARK = 8'h3C;

  localparam logic [REL_W-1:0] REL_YIELDS = 2'd1;
  localparam logic [REL_W-1:0] REL_TAKES  = 2'd2;

  localparam logic [RED_W-1:0] RED_MAX = 6'h3F;

  typedef enum logic [FUNC_W-1:0] {
    FN_BEGIN     = 2'd0,
    FN_LOAD_TERM = 2'd1,
    FN_LOAD_REL  = 2'd2,
    FN_PARSE     = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED  = 2'd0,
    ST_SHIFTED = 2'd1,
    ST_ACCEPT  = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

endpackage

@@ rtl/opp_if.sv @@
// Valid/ready channel interfaces for parser items and results.
interface opp_in_if;
  logic                         valid;
  logic                         ready;
  logic [opp_pkg::FUNC_W-1:0]   func;
  logic [opp_pkg::SYM_W-1:0]    symbol;
  logic [opp_pkg::IDX_W-1:0]    slot;
  logic [opp_pkg::IDX_W-1:0]    row_index;
  logic [opp_pkg::IDX_W-1:0]    col_index;
  logic [opp_pkg::REL_W-1:0]    relation;

  modport source (output valid, func, symbol, slot, row_index, col_index, relation,
                  input ready);
  modport sink (input valid, func, symbol, slot, row_index, col_index, relation,
                output ready);
endinterface

interface opp_out_if;
  logic                          valid;
  logic                          ready;
  logic [opp_pkg::STAT_W-1:0]    status;
  logic [opp_pkg::RED_W-1:0]     reductions;
  logic [opp_pkg::DEPTH_W-1:0]   stack_depth;

  modport source (output valid, status, reductions, stack_depth, input ready);
  modport sink (input valid, status, reductions, stack_depth, output ready);
endinterface

@@ rtl/operator_precedence_parser_unit.sv @@
// Operator precedence parser top level: parse stack and relation table in RAM.
// Begin, load, first symbol and parse after a verdict go straight to the result register; other
// parses check the stack top, read the relation table, then shift or pop down to the marker.
// Throughput: one item at a time; the next is taken the cycle after the result register loads.
// Reset (synchronous, active low): empty stack, no verdict, terminal count 16,
// no result pending. List, table and stack contents are undefined until written.
module operator_precedence_parser_unit #(
  parameter int MAX_TERMINALS = 16,
  parameter int STACK_DEPTH   = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  opp_in_if.sink                      in_ch,
  opp_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [opp_pkg::CNT_W-1:0]   cfg_wdata
);
  import opp_pkg::*;

  localparam int TW  = $clog2(MAX_TERMINALS);
  localparam int RAW = $clog2(MAX_TERMINALS * MAX_TERMINALS);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_REL,
    S_POP,
    S_PUSH,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [SPW-1:0]      sp_r, sp_nxt;
  status_t             verdict_r, verdict_nxt;
  logic [CNT_W-1:0]    tc_r;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [TW-1:0]       col_r, col_nxt;
  logic                col_ok_r, col_ok_nxt;
  logic [RED_W-1:0]    red_r, red_nxt;
  status_t             st_r, st_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [RED_W-1:0]    out_red_r, out_red_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;

  logic [SYM_W-1:0]    stack_mem [STACK_DEPTH];
  logic                stk_we, stk_re;
  logic [AW-1:0]       stk_waddr, stk_raddr;
  logic [SYM_W-1:0]    stk_wdata;
  logic [SYM_W-1:0]    stk_rdata_r;

  logic [REL_W-1:0]    rel_mem [MAX_TERMINALS * MAX_TERMINALS];
  logic                rel_we, rel_re;
  logic [RAW-1:0]      rel_waddr, rel_raddr;
  logic [REL_W-1:0]    rel_rdata_r;

  logic                term_we;
  logic [TW-1:0]       in_idx, top_idx;
  logic                in_hit, top_hit;

  logic                in_accept;
  logic                out_free;
  logic [SPW-1:0]      sp_m1, sp_m2, sp_p1, sp_p2;

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign sp_p1 = sp_r + SPW'(1);
  assign sp_p2 = sp_r + SPW'(2);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.reductions  = out_red_r;
  assign out_ch.stack_depth = out_depth_r;

  assign rel_waddr = RAW'(RAW'(in_ch.row_index) * RAW'(MAX_TERMINALS)
                          + RAW'(in_ch.col_index));
  assign rel_raddr = RAW'(RAW'(top_idx) * RAW'(MAX_TERMINALS) + RAW'(col_r));

  opp_term_table #(
    .MAX_TERMINALS (MAX_TERMINALS)
  ) u_terms (
    .clk     (clk),
    .wr_en   (term_we),
    .wr_slot (in_ch.slot),
    .wr_sym  (in_ch.symbol),
    .count   (tc_r),
    .key_a   (in_ch.symbol),
    .key_b   (stk_rdata_r),
    .idx_a   (in_idx),
    .hit_a   (in_hit),
    .idx_b   (top_idx),
    .hit_b   (top_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    verdict_nxt    = verdict_r;
    sym_nxt        = sym_r;
    col_nxt        = col_r;
    col_ok_nxt     = col_ok_r;
    red_nxt        = red_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_red_nxt    = out_red_r;
    out_depth_nxt  = out_depth_r;
    stk_we         = 1'b0;
    stk_waddr      = sp_r[AW-1:0];
    stk_wdata      = sym_r;
    stk_re         = 1'b0;
    stk_raddr      = sp_m1[AW-1:0];
    rel_we         = 1'b0;
    rel_re         = 1'b0;
    term_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          red_nxt   = '0;
          st_nxt    = ST_LOADED;
          state_nxt = S_EMIT;
          unique case (func_t'(in_ch.func))
            FN_BEGIN: begin
              sp_nxt      = '0;
              verdict_nxt = ST_LOADED;
            end
            FN_LOAD_TERM: begin
              term_we = 1'b1;
            end
            FN_LOAD_REL: begin
              rel_we = (int'(in_ch.row_index) < MAX_TERMINALS) &&
                       (int'(in_ch.col_index) < MAX_TERMINALS);
            end
            FN_PARSE: begin
              sym_nxt    = in_ch.symbol;
              col_nxt    = in_idx;
              col_ok_nxt = in_hit;
              if (verdict_r != ST_LOADED) begin
                st_nxt = verdict_r;
              end else if (sp_r == '0) begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = in_ch.symbol;
                sp_nxt    = SPW'(1);
                st_nxt    = ST_SHIFTED;
              end else begin
                stk_re    = 1'b1;
                state_nxt = S_LOOK;
              end
            end
            default: ;
          endcase
        end
      end

      S_LOOK: begin
        if ((stk_rdata_r == SYM_END) && (sym_r == SYM_END)) begin
          verdict_nxt = ST_ACCEPT;
          st_nxt      = ST_ACCEPT;
          state_nxt   = S_EMIT;
        end else if (!top_hit || !col_ok_r) begin
          verdict_nxt = ST_REJECT;
          st_nxt      = ST_REJECT;
          state_nxt   = S_EMIT;
        end else begin
          rel_re    = 1'b1;
          state_nxt = S_REL;
        end
      end

      S_REL: begin
        if (rel_rdata_r == REL_YIELDS) begin
          if (int'(sp_r) + 2 > STACK_DEPTH) begin
            verdict_nxt = ST_REJECT;
            st_nxt      = ST_REJECT;
            state_nxt   = S_EMIT;
          end else begin
            stk_we    = 1'b1;
            stk_wdata = SYM_MARK;
            state_nxt = S_PUSH;
          end
        end else if (rel_rdata_r == REL_TAKES) begin
          state_nxt = S_POP;
        end else begin
          verdict_nxt = ST_REJECT;
          st_nxt      = ST_REJECT;
          state_nxt   = S_EMIT;
        end
      end

      S_PUSH: begin
        stk_we    = 1'b1;
        stk_waddr = sp_p1[AW-1:0];
        sp_nxt    = sp_p2;
        st_nxt    = ST_SHIFTED;
        state_nxt = S_EMIT;
      end

      // read data holds the current top; one entry popped per cycle
      S_POP: begin
        if (sp_r == '0) begin
          verdict_nxt = ST_REJECT;
          st_nxt      = ST_REJECT;
          state_nxt   = S_EMIT;
        end else if (stk_rdata_r == SYM_MARK) begin
          sp_nxt = sp_m1;
          if (red_r != RED_MAX) begin
            red_nxt = red_r + RED_W'(1);
          end
          if (sp_m1 == '0) begin
            verdict_nxt = ST_REJECT;
            st_nxt      = ST_REJECT;
            state_nxt   = S_EMIT;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = sp_m2[AW-1:0];
            state_nxt = S_LOOK;
          end
        end else begin
          sp_nxt = sp_m1;
          if (sp_m1 != '0) begin
            stk_re    = 1'b1;
            stk_raddr = sp_m2[AW-1:0];
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_red_nxt    = red_r;
          out_depth_nxt  = DEPTH_W'(sp_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      verdict_r   <= ST_LOADED;
      tc_r        <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      verdict_r   <= verdict_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tc_r <= cfg_wdata;
      end
    end
    sym_r        <= sym_nxt;
    col_r        <= col_nxt;
    col_ok_r     <= col_ok_nxt;
    red_r        <= red_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_red_r    <= out_red_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rel_we) begin
      rel_mem[rel_waddr] <= in_ch.relation;
    end
    if (rel_re) begin
      rel_rdata_r <= rel_mem[rel_raddr];
    end
  end

endmodule

@@ rtl/opp_term_table.sv @@
// Terminal symbol list with two parallel first-match lookups.
module opp_term_table #(
  parameter int MAX_TERMINALS = 16
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [opp_pkg::IDX_W-1:0]          wr_slot,
  input  logic [opp_pkg::SYM_W-1:0]          wr_sym,
  input  logic [opp_pkg::CNT_W-1:0]          count,
  input  logic [opp_pkg::SYM_W-1:0]          key_a,
  input  logic [opp_pkg::SYM_W-1:0]          key_b,
  output logic [$clog2(MAX_TERMINALS)-1:0]   idx_a,
  output logic                               hit_a,
  output logic [$clog2(MAX_TERMINALS)-1:0]   idx_b,
  output logic                               hit_b
);
  import opp_pkg::*;

  localparam int TW = $clog2(MAX_TERMINALS);

  logic [SYM_W-1:0] list_r [MAX_TERMINALS];
  logic [TW-1:0]    slot_idx;

  assign slot_idx = TW'(wr_slot);

  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_slot) < MAX_TERMINALS)) begin
      list_r[slot_idx] <= wr_sym;
    end
  end

  // lowest matching index wins
  always_comb begin
    idx_a = '0;
    hit_a = 1'b0;
    idx_b = '0;
    hit_b = 1'b0;
    for (int i = MAX_TERMINALS - 1; i >= 0; i--) begin
      if (i < int'(count)) begin
        if (list_r[i] == key_a) begin
          idx_a = TW'(i);
          hit_a = 1'b1;
        end
        if (list_r[i] == key_b) begin
          idx_b = TW'(i);
          hit_b = 1'b1;
        end
      end
    end
  end

endmodule
